### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by ffca_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// shared constants and types of the first-fit allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int MEM_WORDS = 2048;

    // fixed field widths
    localparam int SIZE_W  = 12;
    localparam int BASE_W  = 11;
    localparam int LIMIT_W = 12;

    // fill mark holds 0..MEM_WORDS
    localparam int FILL_W = $clog2(MEM_WORDS + 1);

    // serial datapath width, one spare bit so the sum never overflows
    localparam int SER_W = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;
    localparam int CNT_W = $clog2(SER_W);

    // answer status codes
    localparam logic STATUS_ALLOCATED = 1'b0;
    localparam logic STATUS_NO_SPACE  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } ffca_state_t;

    // result of one serial pass
    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [SER_W-1:0] sum;
    } ffca_res_t;

endpackage

### hw/rtl/ffca_if.sv
// ----------------------------------------------------------------------------
// ffca request and response channels
// valid/ready channels carrying allocation requests and their answers
// ----------------------------------------------------------------------------
interface ffca_req_if;
    logic                        valid;
    logic                        ready;
    logic [ffca_pkg::SIZE_W-1:0] request_size;

    modport source (output valid, output request_size, input ready);
    modport sink   (input valid, input request_size, output ready);
endinterface

interface ffca_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [ffca_pkg::BASE_W-1:0]  base_address;
    logic [ffca_pkg::LIMIT_W-1:0] limit_address;

    modport source (output valid, output status, output base_address,
                    output limit_address, input ready);
    modport sink   (input valid, input status, input base_address,
                    input limit_address, output ready);
endinterface

### hw/rtl/first_fit_contiguous_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator
// first-fit allocator of contiguous word runs over a word occupancy map
// ----------------------------------------------------------------------------
// Each request asks for request_size contiguous words; the answer carries
// status 0 with base_address and limit_address (one past the run), or status 1
// with both addresses 0 when the size is zero, too large, or no free run fits.
// There is no free operation, so first fit always places a run directly above
// the previous one: the occupancy map is exactly the words below a fill mark,
// which reset clears at once (no clearing pass). A request is served by a
// bit-serial adder and comparator that works fill mark plus size against the
// memory size one bit per cycle, over SER_W (13) bits for the default 2048
// words. One request is in progress at a time. The answer sits in an output
// register, so the next request is accepted while it waits. A finished pass
// waits for that register to be empty or drained before committing.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator (
    input  logic        clk,
    input  logic        rst_n,
    ffca_req_if.sink    req,
    ffca_rsp_if.source  rsp
);

    ffca_pkg::ffca_state_t          state_reg, state_next;
    logic [ffca_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           status_reg, status_next;
    logic [ffca_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [ffca_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic                           start;
    logic                           slot_free;
    ffca_pkg::ffca_res_t            res;

    // request taken only when no pass is running
    assign req.ready = (state_reg == ffca_pkg::ST_IDLE);
    assign start     = req.valid & req.ready;
    // output register empty or being drained this cycle
    assign slot_free = ~out_valid_reg | rsp.ready;

    ffca_serial_unit u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .fill  (fill_reg),
        .size  (req.request_size),
        .res   (res)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ffca_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ffca_pkg::ST_CALC;
                end
            end
            ffca_pkg::ST_CALC:
            begin
                // commit once the serial pass is done and the answer has room
                if (res.valid && slot_free)
                begin
                    state_next     = ffca_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    if (res.ok)
                    begin
                        // run starts at the fill mark, which moves to its end
                        status_next = ffca_pkg::STATUS_ALLOCATED;
                        base_next   = ffca_pkg::BASE_W'(fill_reg);
                        limit_next  = ffca_pkg::LIMIT_W'(res.sum);
                        fill_next   = ffca_pkg::FILL_W'(res.sum);
                    end
                    else
                    begin
                        status_next = ffca_pkg::STATUS_NO_SPACE;
                        base_next   = '0;
                        limit_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = ffca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffca_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        base_reg   <= base_next;
        limit_reg  <= limit_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.base_address  = base_reg;
    assign rsp.limit_address = limit_reg;

endmodule

### hw/rtl/ffca_serial_unit.sv
// ----------------------------------------------------------------------------
// ffca_serial_unit
// bit-serial add of fill mark and size with a serial compare against memory size
// ----------------------------------------------------------------------------
module ffca_serial_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ffca_pkg::FILL_W-1:0]   fill,
    input  logic [ffca_pkg::SIZE_W-1:0]   size,
    output ffca_pkg::ffca_res_t           res
);

    logic [ffca_pkg::SER_W-1:0] a_sh_reg, a_sh_next;
    logic [ffca_pkg::SER_W-1:0] b_sh_reg, b_sh_next;
    logic [ffca_pkg::SER_W-1:0] m_sh_reg, m_sh_next;
    logic [ffca_pkg::SER_W-1:0] sum_sh_reg, sum_sh_next;
    logic                       carry_reg, carry_next;
    logic                       gt_reg, gt_next;
    logic                       nz_reg, nz_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ffca_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       s_bit;

    always_comb
    begin
        a_sh_next   = a_sh_reg;
        b_sh_next   = b_sh_reg;
        m_sh_next   = m_sh_reg;
        sum_sh_next = sum_sh_reg;
        carry_next  = carry_reg;
        gt_next     = gt_reg;
        nz_next     = nz_reg;
        busy_next   = busy_reg;
        done_next   = done_reg;
        cnt_next    = cnt_reg;
        s_bit       = a_sh_reg[0] ^ b_sh_reg[0] ^ carry_reg;

        if (start)
        begin
            a_sh_next  = ffca_pkg::SER_W'(fill);
            b_sh_next  = ffca_pkg::SER_W'(size);
            m_sh_next  = ffca_pkg::SER_W'(ffca_pkg::MEM_WORDS);
            carry_next = 1'b0;
            gt_next    = 1'b0;
            nz_next    = 1'b0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            // lsb first: sum bit, carry, running compare against the memory size
            sum_sh_next = {s_bit, sum_sh_reg[ffca_pkg::SER_W-1:1]};
            carry_next  = (a_sh_reg[0] & b_sh_reg[0]) | (carry_reg & (a_sh_reg[0] ^ b_sh_reg[0]));
            if (s_bit != m_sh_reg[0])
            begin
                gt_next = s_bit;
            end
            nz_next   = nz_reg | b_sh_reg[0];
            a_sh_next = {1'b0, a_sh_reg[ffca_pkg::SER_W-1:1]};
            b_sh_next = {1'b0, b_sh_reg[ffca_pkg::SER_W-1:1]};
            m_sh_next = {1'b0, m_sh_reg[ffca_pkg::SER_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ffca_pkg::CNT_W'(ffca_pkg::SER_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
            gt_reg    <= 1'b0;
            nz_reg    <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            carry_reg <= carry_next;
            gt_reg    <= gt_next;
            nz_reg    <= nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg   <= a_sh_next;
        b_sh_reg   <= b_sh_next;
        m_sh_reg   <= m_sh_next;
        sum_sh_reg <= sum_sh_next;
    end

    assign res.valid = done_reg;
    assign res.ok    = nz_reg & ~gt_reg;
    assign res.sum   = sum_sh_reg;

endmodule

### hw/rtl/ffca_checker.sv
// ----------------------------------------------------------------------------
// ffca_checker
// port-level checks of the first-fit allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffca_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         status,
    input logic [ffca_pkg::BASE_W-1:0]  base_address,
    input logic [ffca_pkg::LIMIT_W-1:0] limit_address
);

    logic                         out_fire;
    logic                         ok_shown;
    logic                         fail_shown;
    logic [ffca_pkg::LIMIT_W-1:0] base_wide;
    logic [ffca_pkg::LIMIT_W-1:0] last_limit_reg, last_limit_next;

    assign out_fire   = out_valid & out_ready;
    assign ok_shown   = out_valid && (status == ffca_pkg::STATUS_ALLOCATED);
    assign fail_shown = out_valid && (status == ffca_pkg::STATUS_NO_SPACE);
    assign base_wide  = ffca_pkg::LIMIT_W'(base_address);

    // end of the most recent successful run
    always_comb
    begin
        last_limit_next = last_limit_reg;
        if (out_fire && status == ffca_pkg::STATUS_ALLOCATED)
        begin
            last_limit_next = limit_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_limit_reg <= '0;
        end
        else
        begin
            last_limit_reg <= last_limit_next;
        end
    end

    // a response waits until taken
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // a failed answer carries zero addresses
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, fail_shown, base_address == '0 && limit_address == '0)
    // a successful run is never empty
    `ASSERT_IMPLY(a_run_nonempty, clk, rst_n, ok_shown, base_wide < limit_address)
    // runs are packed: each starts where the previous one ended
    `ASSERT_IMPLY(a_run_packed, clk, rst_n, ok_shown, base_wide == last_limit_reg)

endmodule

bind first_fit_contiguous_allocator ffca_checker u_ffca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .base_address  (rsp.base_address),
    .limit_address (rsp.limit_address)
);
